@@ src/kvcr_pkg.sv @@
package kvcr_pkg;

  // Default sizes of the store.
  localparam int unsigned DefEntries   = 16;
  localparam int unsigned DefValueBits = 64;

  // Fixed widths of the interface fields.
  localparam int unsigned KeyW     = 32;
  localparam int unsigned DataW    = 64;
  localparam int unsigned CapW     = 5;
  localparam int unsigned PolW     = 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;

  // Operation codes.
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncGet    = 1'b1;

  // Replacement policies; the unused code behaves as LRU.
  localparam logic [PolW-1:0] PolFifo = 2'd0;
  localparam logic [PolW-1:0] PolLru  = 2'd1;
  localparam logic [PolW-1:0] PolLifo = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CfgIdxW-1:0] CfgCapacity = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgPolicy   = 4'd1;
  localparam logic [CapW-1:0]    CapReset    = 5'd16;
  localparam logic [PolW-1:0]    PolReset    = PolLru;

  typedef struct packed {
    logic                   func;
    logic signed [KeyW-1:0] lookup_key;
    logic [DataW-1:0]       data_in;
  } kvcr_in_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] data_out;
    logic             evicted;
  } kvcr_out_t;

  typedef enum logic {
    StIdle,
    StLookup
  } kvcr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic execute;
  } kvcr_cmd_t;

endpackage

@@ src/kvcr_ctrl.sv @@
module kvcr_ctrl
  import kvcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output kvcr_cmd_t cmd_o
);

  kvcr_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StLookup: begin
        cmd_o.execute = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/kvcr_datapath.sv @@
module kvcr_datapath
  import kvcr_pkg::*;
#(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kvcr_cmd_t           cmd_i,
  input  kvcr_in_t            in_data_i,
  output kvcr_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  // Configuration registers.
  logic [CapW-1:0] capacity_q;
  logic [PolW-1:0] policy_q;

  // Operation being worked on.
  logic                  func_q;
  logic [KeyW-1:0]       key_q;
  logic [VALUE_BITS-1:0] val_q;

  // Entry state: valid bits, keys and ranks per entry, values in a memory.
  logic [ENTRIES-1:0]    valid_q;
  logic [CntW-1:0]       count_q;
  logic [KeyW-1:0]       key_mem [ENTRIES];
  logic [IdxW-1:0]       rank_q  [ENTRIES];
  logic [VALUE_BITS-1:0] data_mem [ENTRIES];
  logic [VALUE_BITS-1:0] rdata_q;

  // Result register.
  logic hit_q;
  logic evict_q;
  logic dsel_q;

  // Lookup and replacement decision.
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] valid_ev;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] set_rank;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    hit_rank;
  logic [IdxW-1:0]    free_idx;
  logic [IdxW-1:0]    wr_idx;
  logic [IdxW-1:0]    last_rank;
  logic [IdxW-1:0]    vic_rank;
  logic [IdxW-1:0]    thr_rank;
  logic [IdxW-1:0]    new_rank;
  logic [CapW-1:0]    cap_nz;
  logic               hit;
  logic               lru;
  logic               lifo;
  logic               full;
  logic               ins_new;
  logic               do_evict;
  logic               touch;
  logic               dec_en;

  // Configuration writes; other indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
      policy_q   <= PolReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgCapacity) begin
        capacity_q <= cfg_data_i[CapW-1:0];
      end else if (cfg_index_i == CfgPolicy) begin
        policy_q <= cfg_data_i[PolW-1:0];
      end
    end
  end

  // Input register, loaded when a beat is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_data_i.func;
      key_q  <= in_data_i.lookup_key;
      val_q  <= in_data_i.data_in[VALUE_BITS-1:0];
    end
  end

  // Policy decode and fullness; a capacity above the store size acts as the size.
  always_comb begin
    lifo   = (policy_q == PolLifo);
    lru    = !lifo && (policy_q != PolFifo);
    cap_nz = (capacity_q == '0) ? CapW'(1) : capacity_q;
    full   = (CmpW'(count_q) >= CmpW'(cap_nz)) || (count_q == CntW'(ENTRIES));
  end

  // Parallel key compare; keys of valid entries are unique, so at most one match bit is set.
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_mem[i] == key_q);
      if (match[i]) begin
        hit_idx  = hit_idx | IdxW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
    end
    hit = |match;
  end

  // Victim selection by rank and the lowest free entry after eviction.
  always_comb begin
    last_rank = IdxW'(count_q - 1'b1);
    ins_new   = (func_q == FuncInsert) && !hit;
    do_evict  = ins_new && full;
    touch     = hit && ((func_q == FuncInsert) || lru);
    vic_rank  = lifo ? last_rank : '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      victim[i] = do_evict && valid_q[i] && (rank_q[i] == vic_rank);
    end
    valid_ev = valid_q & ~victim;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        free_idx = IdxW'(i);
      end
    end
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      free_oh[i] = ins_new && (free_idx == IdxW'(i));
    end
    thr_rank = touch ? hit_rank : vic_rank;
    dec_en   = touch || do_evict;
    new_rank = (touch || do_evict) ? last_rank : IdxW'(count_q);
    set_rank = (touch ? match : '0) | free_oh;
    wr_idx   = hit ? hit_idx : free_idx;
  end

  // Valid bits and entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.execute && ins_new) begin
      valid_q <= valid_ev | free_oh;
      if (!do_evict) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Keys and ranks per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          key_mem[i] <= key_q;
        end
        if (set_rank[i]) begin
          rank_q[i] <= new_rank;
        end else if (dec_en && valid_ev[i] && (rank_q[i] > thr_rank)) begin
          rank_q[i] <= rank_q[i] - 1'b1;
        end
      end
    end
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (func_q == FuncInsert) begin
        data_mem[wr_idx] <= val_q;
      end
      rdata_q <= data_mem[hit_idx];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      hit_q   <= hit;
      evict_q <= do_evict;
      dsel_q  <= hit && (func_q == FuncGet);
    end
  end

  assign out_data_o.hit      = hit_q;
  assign out_data_o.evicted  = evict_q;
  assign out_data_o.data_out = dsel_q ? DataW'(rdata_q) : '0;

endmodule

@@ src/key_value_cache_replacement_core.sv @@
// Fully associative key-value store with FIFO, LRU or LIFO replacement. The
// beat is registered on acceptance, and then, in the lookup state, all keys
// are compared in parallel, the victim is chosen by its recency rank and the
// entry state is updated, with the result loaded into an output register.
// A new input beat is taken while that result waits; the lookup cycle holds
// only if the previous result has still not been taken.
// The store is empty after reset with no clearing pass. Configuration writes
// are always ready and must be issued only while no operation is in flight.
module key_value_cache_replacement_core
  import kvcr_pkg::*;
#(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kvcr_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kvcr_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  kvcr_cmd_t cmd;

  // Configuration beats are taken at once.
  assign cfg_ready_o = 1'b1;

  kvcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  kvcr_datapath #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

@@ dv/key_value_cache_replacement_core_checker.sv @@
module key_value_cache_replacement_core_checker
  import kvcr_pkg::*;
#(
  parameter int unsigned ENTRIES = DefEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  kvcr_in_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  kvcr_out_t           out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the store and its settings.
  logic             line_valid [ENTRIES];
  logic [KeyW-1:0]  line_key   [ENTRIES];
  logic [DataW-1:0] line_data  [ENTRIES];
  int unsigned      line_rank  [ENTRIES];
  logic [CapW-1:0]  cap_reg;
  logic [PolW-1:0]  pol_reg;

  kvcr_out_t   expected_replies [$];
  int unsigned mismatches = 0;

  assign errors_o = mismatches;

  // Move an entry to the newest rank; the younger entries close the gap.
  task automatic promote(input int e, input int unsigned held);
    int unsigned old_rank;
    old_rank = line_rank[e];
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] > old_rank) begin
        line_rank[i]--;
      end
    end
    line_rank[e] = held - 1;
  endtask

  // Drop the entry holding a given rank and shift the younger ones down.
  task automatic drop_rank(input int unsigned r);
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] == r) begin
        line_valid[i] = 1'b0;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] > r) begin
        line_rank[i]--;
      end
    end
  endtask

  // Apply one operation to the shadow store and work out its reply.
  task automatic run_access(input kvcr_in_t beat, output kvcr_out_t res);
    int unsigned held;
    int unsigned limit;
    int          hit_idx;
    bit          evict_newest;
    bit          recency;
    bit          placed;
    held = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i]) begin
        held++;
      end
    end
    limit = cap_reg;
    if (limit == 0) begin
      limit = 1;
    end
    if (limit > ENTRIES) begin
      limit = ENTRIES;
    end
    evict_newest = (pol_reg == PolLifo);
    // The spare policy code behaves as LRU.
    recency = !(pol_reg == PolFifo || pol_reg == PolLifo);
    hit_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_idx < 0 && line_valid[i] && line_key[i] == beat.lookup_key) begin
        hit_idx = i;
      end
    end
    res = '0;
    if (beat.func == FuncGet) begin
      if (hit_idx >= 0) begin
        res.hit      = 1'b1;
        res.data_out = line_data[hit_idx];
        if (recency) begin
          promote(hit_idx, held);
        end
      end
    end else if (hit_idx >= 0) begin
      // Overwrite of a present key: it becomes the newest under every policy.
      res.hit = 1'b1;
      line_data[hit_idx] = beat.data_in;
      promote(hit_idx, held);
    end else begin
      // A full store (or one above a lowered capacity) gives up one entry.
      if (held >= limit && held > 0) begin
        drop_rank(evict_newest ? held - 1 : 0);
        held--;
        res.evicted = 1'b1;
      end
      placed = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!placed && !line_valid[i]) begin
          line_valid[i] = 1'b1;
          line_key[i]   = beat.lookup_key;
          line_data[i]  = beat.data_in;
          line_rank[i]  = held;
          placed        = 1'b1;
        end
      end
    end
  endtask

  // Watch all three channels; results are compared before new beats are predicted.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    kvcr_out_t want;
    kvcr_out_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
      end
      cap_reg = CapReset;
      pol_reg = PolReset;
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgCapacity) begin
          cap_reg = cfg_data_i[CapW-1:0];
        end else if (cfg_index_i == CfgPolicy) begin
          pol_reg = cfg_data_i[PolW-1:0];
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with nothing outstanding: hit=%0d data=%h evicted=%0d",
                     $time, out_data_i.hit, out_data_i.data_out, out_data_i.evicted);
          end
        end else begin
          want = expected_replies.pop_front();
          if (out_data_i.hit !== want.hit || out_data_i.data_out !== want.data_out ||
              out_data_i.evicted !== want.evicted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: want hit=%0d data=%h ev=%0d, got hit=%0d data=%h ev=%0d",
                       $time, want.hit, want.data_out, want.evicted,
                       out_data_i.hit, out_data_i.data_out, out_data_i.evicted);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        run_access(in_data_i, fresh);
        expected_replies.push_back(fresh);
      end
      pending_o <= expected_replies.size();
    end
  end

endmodule

@@ dv/key_value_cache_replacement_core_test.sv @@
module key_value_cache_replacement_core_test
  import kvcr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  kvcr_in_t            in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                cfg_ready_o;
  kvcr_out_t           out_data_o;

  int unsigned     pending_replies;
  int unsigned     fail_count;
  int unsigned     sent = 0;
  bit              steady = 1'b0;
  logic [KeyW-1:0] key_pool [32];

  key_value_cache_replacement_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  key_value_cache_replacement_core_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pending_o  (pending_replies),
    .errors_o   (fail_count)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #500_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one operation after a random gap and hold it until it is taken.
  task automatic issue(input logic f, input logic [KeyW-1:0] k, input logic [DataW-1:0] d);
    kvcr_in_t beat;
    int       gap;
    beat.func       = f;
    beat.lookup_key = k;
    beat.data_in    = d;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // Stop offering and wait until every reply has been seen, plus the pipeline depth.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_replies != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write capacity and policy back to back, optionally followed by a write to a spare index.
  task automatic program_cache(input logic [CfgDataW-1:0] cap_byte,
                               input logic [CfgDataW-1:0] pol_byte, input bit stray);
    logic [CfgIdxW-1:0]  idx [3];
    logic [CfgDataW-1:0] val [3];
    int                  writes;
    idx[0] = CfgCapacity;
    val[0] = cap_byte;
    idx[1] = CfgPolicy;
    val[1] = pol_byte;
    idx[2] = CfgIdxW'($urandom_range(CfgPolicy + 1, (1 << CfgIdxW) - 1));
    val[2] = CfgDataW'($urandom);
    writes = stray ? 3 : 2;
    for (int w = 0; w < writes; w++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[w];
      cfg_data_i  <= val[w];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, with two long hold-offs so the input side backs up.
  initial begin : receiver
    int          stall;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      if (taken == 200 || taken == 1000) begin
        stall = 80;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 5);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] cap_byte;
    logic [CfgDataW-1:0] pol_byte;
    int unsigned         eff_cap;
    int unsigned         pool_size;
    int unsigned         phase_len;
    logic                f;
    logic [KeyW-1:0]     k;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset: full capacity under LRU, extreme keys and values.
    issue(FuncGet, 32'h8000_0000, '1);
    issue(FuncInsert, 32'h7FFF_FFFF, '1);
    issue(FuncInsert, 32'h8000_0000, '0);
    issue(FuncInsert, '0, 64'h0123_4567_89AB_CDEF);
    issue(FuncGet, 32'h7FFF_FFFF, '1);
    issue(FuncInsert, 32'h8000_0000, 64'hFEDC_BA98_7654_3210);
    issue(FuncGet, 32'hFFFF_FFFF, '0);
    issue(FuncGet, 32'h8000_0000, '0);
    drain();

    // Capacity lowered below the three entries held, FIFO eviction.
    program_cache(8'd2, CfgDataW'(PolFifo), 1'b0);
    issue(FuncInsert, 32'h0000_0001, 64'h5555_5555_5555_5555);
    issue(FuncGet, 32'h7FFF_FFFF, '0);
    issue(FuncInsert, 32'h0000_0002, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Capacity zero acts as one; LIFO; a write to a spare index changes nothing.
    program_cache('0, CfgDataW'(PolLifo), 1'b1);
    issue(FuncInsert, 32'h0000_0003, 64'h1);
    issue(FuncInsert, 32'h0000_0004, 64'h2);
    issue(FuncGet, 32'h0000_0003, '0);
    issue(FuncInsert, 32'h0000_0004, 64'h3);
    drain();

    // Capacity above the store size and the spare policy code.
    program_cache(8'hFF, 8'hFF, 1'b0);
    issue(FuncInsert, 32'h0000_0005, '1);
    issue(FuncGet, 32'h0000_0004, '0);
    issue(FuncGet, 32'h0000_0005, '0);
    drain();

    // Random phases: keys mostly from a pool a little larger than the capacity.
    while (sent < 1950) begin
      case ($urandom_range(0, 5))
        0:       cap_byte = 8'd1;
        1:       cap_byte = 8'd16;
        2:       cap_byte = 8'd0;
        3:       cap_byte = CfgDataW'($urandom);
        default: cap_byte = CfgDataW'($urandom_range(1, 16));
      endcase
      pol_byte = $urandom_range(0, 1) ? CfgDataW'($urandom_range(0, 3)) : CfgDataW'($urandom);
      program_cache(cap_byte, pol_byte, $urandom_range(0, 4) == 0);
      steady = ($urandom_range(0, 3) == 0);

      eff_cap = cap_byte[CapW-1:0];
      if (eff_cap == 0) begin
        eff_cap = 1;
      end
      if (eff_cap > 16) begin
        eff_cap = 16;
      end
      pool_size = eff_cap + $urandom_range(0, 8);
      for (int i = 0; i < 32; i++) begin
        key_pool[i] = $urandom;
      end

      phase_len = $urandom_range(80, 180);
      repeat (phase_len) begin
        f = $urandom_range(0, 1) ? FuncGet : FuncInsert;
        k = ($urandom_range(0, 9) == 0) ? KeyW'($urandom) :
            key_pool[$urandom_range(0, pool_size - 1)];
        issue(f, k, {$urandom, $urandom});
      end
      drain();
    end

    if (fail_count == 0 && pending_replies == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
